### sv/interval_booking_table_core_defines.svh
// assertion macros for the interval booking table core
`ifndef INTERVAL_BOOKING_TABLE_CORE_DEFINES_SVH
`define INTERVAL_BOOKING_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define IBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define IBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IBT_ASSERT_NOW(lbl, ante, cons, msg)
`define IBT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/ibt_pkg.sv
// shared types and constants for the interval booking table
package ibt_pkg;

  localparam int unsigned IBT_ENTRIES = 64;
  localparam int unsigned TIME_W      = 32;

  // result status codes
  localparam logic [1:0] ST_BOOKED  = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // update broadcast to every cell at commit
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_EXT_L = 2'd1,
    OP_EXT_R = 2'd2,
    OP_INS   = 2'd3
  } ibt_op_e;

  // flags or-ed along the chain
  typedef struct packed {
    logic ovl;
    logic adj_l;
    logic adj_r;
  } ibt_flags_t;

endpackage

### sv/ibt_cell.sv
// one table entry with its local compare and chain flag register
module ibt_cell #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IDX     = 0,
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ibt_pkg::TIME_W-1:0] req_start_i,
  input  logic [ibt_pkg::TIME_W-1:0] req_end_i,
  input  logic [CNT_W-1:0]          count_i,
  input  logic                      clear_i,
  input  logic                      scan_i,
  input  ibt_pkg::ibt_op_e          op_i,
  input  ibt_pkg::ibt_flags_t       chain_i,
  output ibt_pkg::ibt_flags_t       chain_o
);
  import ibt_pkg::*;

  logic [TIME_W-1:0] st_q, st_d;
  logic [TIME_W-1:0] en_q, en_d;
  ibt_flags_t        flg_q, flg_d;
  ibt_flags_t        local_flg;
  logic              occ;

  assign occ = CNT_W'(IDX) < count_i;

  always_comb begin
    local_flg.ovl   = occ && (st_q < req_end_i) && (en_q > req_start_i);
    local_flg.adj_l = occ && (en_q == req_start_i);
    local_flg.adj_r = occ && (st_q == req_end_i);
  end

  always_comb begin
    flg_d = flg_q;
    if (clear_i) begin
      flg_d = '0;
    end else if (scan_i) begin
      flg_d = chain_i | local_flg;
    end
  end

  always_comb begin
    st_d = st_q;
    en_d = en_q;
    unique case (op_i)
      OP_EXT_L: if (local_flg.adj_l) begin
        en_d = req_end_i;
      end
      OP_EXT_R: if (local_flg.adj_r) begin
        st_d = req_start_i;
      end
      OP_INS: if (count_i == CNT_W'(IDX)) begin
        st_d = req_start_i;
        en_d = req_end_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flg_q <= '0;
    end else begin
      flg_q <= flg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    en_q <= en_d;
  end

  assign chain_o = flg_q;

endmodule

### sv/interval_booking_table_core.sv
// top level of the interval booking table: cell chain, sequencer and result register
//
// channel   dir  payload (low bit first)
// s_axis    in   req_start[31:0], req_end[63:32]
// m_axis    out  accepted[0], status[2:1], zero pad[7:3]
//
// each request is latched, then the overlap and adjacency flags ripple
// through the registered cell chain, and then the request commits.
// the output register holds a finished result while the next request is taken;
// commit waits while that register is still full.
// reset clears the entry count, the sequencer and the chain flags.
`include "interval_booking_table_core_defines.svh"

module interval_booking_table_core #(
  parameter int unsigned ENTRIES = ibt_pkg::IBT_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // req_start[31:0], req_end[63:32]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o    // accepted[0], status[2:1], zero[7:3]
);
  import ibt_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned SCN_W = $clog2(ENTRIES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SCN_W-1:0]  scan_q, scan_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] rs_q, rs_d;
  logic [TIME_W-1:0] re_q, re_d;
  logic              ov_q, ov_d;
  logic              oacc_q, oacc_d;
  logic [1:0]        ost_q, ost_d;

  logic              in_xact;
  logic              slot_free;
  ibt_op_e           op;
  logic [1:0]        status;
  ibt_flags_t        chain [ENTRIES+1];
  ibt_flags_t        fin;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xact         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !ov_q || m_axis_tready_i;
  assign chain[0]        = '0;
  assign fin             = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ibt_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_start_i(rs_q),
      .req_end_i  (re_q),
      .count_i    (cnt_q),
      .clear_i    (in_xact),
      .scan_i     (state_q == S_SCAN),
      .op_i       (op),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1])
    );
  end

  // decision from the flags that reached the end of the chain
  always_comb begin
    op     = OP_NONE;
    status = ST_BOOKED;
    priority if (re_q <= rs_q) begin
      status = ST_INVALID;
    end else if (fin.ovl) begin
      status = ST_OVERLAP;
    end else if (fin.adj_l) begin
      op = OP_EXT_L;
    end else if (fin.adj_r) begin
      op = OP_EXT_R;
    end else if (cnt_q < CNT_W'(ENTRIES)) begin
      op = OP_INS;
    end else begin
      status = ST_FULL;
    end
    if (!(state_q == S_DONE && slot_free)) begin
      op = OP_NONE;
    end
  end

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    cnt_d   = cnt_q;
    rs_d    = rs_q;
    re_d    = re_q;
    ov_d    = ov_q;
    oacc_d  = oacc_q;
    ost_d   = ost_q;
    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: if (in_xact) begin
        rs_d    = s_axis_tdata_i[31:0];
        re_d    = s_axis_tdata_i[63:32];
        scan_d  = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == SCN_W'(ENTRIES - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: if (slot_free) begin
        ov_d    = 1'b1;
        ost_d   = status;
        oacc_d  = (status == ST_BOOKED);
        state_d = S_IDLE;
        if (op == OP_INS) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q   <= rs_d;
    re_q   <= re_d;
    oacc_q <= oacc_d;
    ost_q  <= ost_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {5'b0, ost_q, oacc_q};

  `IBT_ASSERT_NOW(a_cnt_max, 1'b1, cnt_q <= CNT_W'(ENTRIES), "entry count above table size")
  `IBT_ASSERT_NOW(a_acc_status, ov_q, oacc_q == (ost_q == ST_BOOKED), "accepted flag mismatch")
  `IBT_ASSERT_NEXT(a_cnt_scan, state_q == S_SCAN, $stable(cnt_q), "count moved during scan")

endmodule

### test/interval_booking_table_core_checker.sv
// checker for the interval booking table: watches both channels, predicts and compares
`timescale 1ns / 100ps

module interval_booking_table_core_checker #(
  parameter int unsigned ENTRIES = ibt_pkg::IBT_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [63:0] s_axis_tdata_i,   // req_start[31:0], req_end[63:32]
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // accepted[0], status[2:1], zero[7:3]
  output int unsigned pending_o,
  output int unsigned errors_o
);

  import ibt_pkg::*;

  typedef logic [TIME_W-1:0] stamp_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] status;
  } booking_result_t;

  // shadow copy of the reserved intervals
  stamp_t      slot_start [ENTRIES];
  stamp_t      slot_end   [ENTRIES];
  int unsigned slot_count;

  booking_result_t booking_results_q [$];
  int unsigned     error_count;

  // works out the outcome of one request and updates the shadow table
  function automatic booking_result_t book_interval(input stamp_t req_s, input stamp_t req_e);
    bit              has_l;
    bit              has_r;
    int unsigned     li;
    int unsigned     ri;
    logic [1:0]      st;
    booking_result_t res;
    has_l = 1'b0;
    has_r = 1'b0;
    li    = 0;
    ri    = 0;
    if (req_e <= req_s) begin
      st = ST_INVALID;
    end else begin
      for (int unsigned i = 0; i < slot_count; i++) begin
        if (slot_start[i] <= req_s) begin
          if (!has_l || slot_start[i] > slot_start[li]) begin
            has_l = 1'b1;
            li    = i;
          end
        end else if (!has_r || slot_start[i] < slot_start[ri]) begin
          has_r = 1'b1;
          ri    = i;
        end
      end
      if (has_l && slot_end[li] > req_s) begin
        st = ST_OVERLAP;
      end else if (has_r && slot_start[ri] < req_e) begin
        st = ST_OVERLAP;
      end else if (has_l && slot_end[li] == req_s) begin
        // left wins even when right touches too; the two are not merged
        slot_end[li] = req_e;
        st           = ST_BOOKED;
      end else if (has_r && slot_start[ri] == req_e) begin
        slot_start[ri] = req_s;
        st             = ST_BOOKED;
      end else if (slot_count >= ENTRIES) begin
        st = ST_FULL;
      end else begin
        slot_start[slot_count] = req_s;
        slot_end[slot_count]   = req_e;
        slot_count++;
        st = ST_BOOKED;
      end
    end
    res.accepted = (st == ST_BOOKED);
    res.status   = st;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    booking_result_t want;
    booking_result_t got;
    if (!rst_ni) begin
      slot_count  = 0;
      error_count = 0;
      booking_results_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        booking_results_q.push_back(book_interval(s_axis_tdata_i[31:0], s_axis_tdata_i[63:32]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.accepted = m_axis_tdata_i[0];
        got.status   = m_axis_tdata_i[2:1];
        if (booking_results_q.size() == 0) begin
          $error("result transaction with no booking outstanding: accepted %0d status %0d",
                 got.accepted, got.status);
          error_count++;
        end else begin
          want = booking_results_q.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            error_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
        end
      end
      pending_o <= booking_results_q.size();
      errors_o  <= error_count;
    end
  end

endmodule

### test/interval_booking_table_core_tb.sv
// testbench top for the interval booking table: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module interval_booking_table_core_tb;

  import ibt_pkg::*;

  localparam int unsigned ENTRIES      = IBT_ENTRIES;
  localparam int unsigned RANDOM_ITEMS = 1280;
  localparam int unsigned IDLE_LIMIT   = 20 * (ENTRIES + 2);

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i;   // req_start[31:0], req_end[63:32]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;   // accepted[0], status[2:1], zero[7:3]

  int unsigned pending;
  int unsigned errors;
  int unsigned idle_cycles;
  bit          tx_calm;
  bit          rx_calm;
  bit          stim_done;

  interval_booking_table_core #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  interval_booking_table_core_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // ends the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** interval_booking_table_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, with calm stretches of none
  initial begin
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    rx_calm         = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_calm = ~rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // one booking request transaction, after a random gap
  task automatic send_booking(input logic [31:0] req_s, input logic [31:0] req_e);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {req_e, req_s};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] unit;
    logic [31:0] req_s;
    logic [31:0] req_e;
    int unsigned sent;
    int unsigned burst;
    int unsigned pick;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    idle_cycles     = 0;
    tx_calm         = 1'b0;
    stim_done       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // invalid intervals on an empty table
    send_booking(32'd0, 32'd0);
    send_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_booking(32'd5, 32'd3);
    send_booking(32'hFFFF_FFFF, 32'd0);
    // insert, overlaps on either side, extend left, extend right
    send_booking(32'd100, 32'd200);
    send_booking(32'd150, 32'd160);
    send_booking(32'd50, 32'd150);
    send_booking(32'd200, 32'd300);
    send_booking(32'd50, 32'd100);
    send_booking(32'd300, 32'd400);
    // gap touched by both neighbours: only left grows
    send_booking(32'd500, 32'd600);
    send_booking(32'd400, 32'd500);
    send_booking(32'd450, 32'd550);
    send_booking(32'd499, 32'd501);
    send_booking(32'd0, 32'd50);
    send_booking(32'd0, 32'd1);
    // top of the time range
    send_booking(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_booking(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_booking(32'd600, 32'hFFFF_FFF0);
    send_booking(32'd700, 32'd800);
    send_booking(32'hAAAA_5555, 32'h5555_AAAA);
    send_booking(32'h7FFF_FFFF, 32'h8000_0000);

    // bursts on a grid of small units so that edges meet often; the table
    // fills early and later bursts probe full-table behaviour
    sent = 0;
    base = $urandom_range(0, 32'hFFFF_F000);
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) base = $urandom_range(0, 32'hFFFF_F000);
      unit    = $urandom_range(1, 8);
      tx_calm = ($urandom_range(0, 3) == 0);
      burst   = $urandom_range(20, 60);
      for (int unsigned k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          req_s = base + unit * $urandom_range(0, 63);
          req_e = req_s + unit * $urandom_range(1, 6);
        end else if (pick < 80) begin
          req_s = 32'hFFFF_FFFF - $urandom_range(1, 64);
          req_e = $urandom_range(req_s, 32'hFFFF_FFFF);
        end else if (pick < 90) begin
          req_s = $urandom;
          req_e = $urandom;
        end else begin
          req_s = $urandom_range(1, 32'hFFFF_FFFF);
          req_e = $urandom_range(0, req_s);
        end
        send_booking(req_s, req_e);
        sent++;
      end
    end
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;

    do @(posedge clk_i); while (pending != 0);
    repeat (2 * (ENTRIES + 2)) @(posedge clk_i);
    if (errors == 0) begin
      $display("** interval_booking_table_core: PASSED **");
    end else begin
      $display("** interval_booking_table_core: FAILED **");
    end
    $finish;
  end

endmodule
